FILE: rtl/wsp_pkg.sv
// Shared constants, types and state codes for the wheel speed PID / PWM core.
// Used by wsp_divider, wsp_mac and wheel_speed_pid_pwm_core. No dependencies.
package wsp_pkg;

	// Block configuration
	localparam int NUM_WHEELS = 2;
	localparam int FRAC_BITS  = 12;
	localparam int WIDX_W     = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
	localparam int FULL_SCALE = 1 << FRAC_BITS;
	localparam int GAIN_FRAC  = 8;

	// Field widths
	localparam int TIME_W   = 16;
	localparam int SPEED_W  = 16;
	localparam int CHG_W    = 17;
	localparam int ERR_W    = 17;
	localparam int DERIV_W  = 18;
	localparam int SUM_W    = 32;
	localparam int GAIN_W   = 16;
	localparam int SCALE_W  = 32;
	localparam int DB_W     = 13;
	localparam int DUTY_W   = 13;
	localparam int DRV_W    = FRAC_BITS + 2;

	// Shared multiplier: signed A x signed B, full product
	localparam int MUL_A_W  = SCALE_W + 1;
	localparam int MUL_B_W  = GAIN_W + 1;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;

	// Divider: |pulses| * scale fits in SCALE_W + SPEED_W - 1 bits
	localparam int DVD_W    = SCALE_W + SPEED_W - 1;
	localparam int CNT_W    = $clog2(DVD_W + 1);

	// Stream and configuration port widths
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_SCALE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND       = 3'd4;

	localparam logic [DB_W-1:0] DEADBAND_RESET = 13'd205;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_MULV   = 11'b000_0000_0010,
		ST_DSTART = 11'b000_0000_0100,
		ST_DIV    = 11'b000_0000_1000,
		ST_PREP   = 11'b000_0001_0000,
		ST_MP     = 11'b000_0010_0000,
		ST_MI     = 11'b000_0100_0000,
		ST_MD     = 11'b000_1000_0000,
		ST_MACC   = 11'b001_0000_0000,
		ST_CLAMP  = 11'b010_0000_0000,
		ST_OUT    = 11'b100_0000_0000
	} state_t;

	// Control for the shared multiply-accumulate unit
	typedef struct packed {
		logic mul_en;
		logic acc_clr;
		logic acc_add;
	} mac_ctl_t;

endpackage

FILE: rtl/wsp_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wsp_pkg for widths.
module wsp_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [wsp_pkg::DVD_W-1:0]  dividend,
	input  logic [wsp_pkg::TIME_W-1:0] divisor,
	output logic                       done,
	output logic [wsp_pkg::DVD_W-1:0]  quotient
);

	logic                       busy_q;
	logic                       done_q;
	logic [wsp_pkg::CNT_W-1:0]  cnt_q;
	logic [wsp_pkg::TIME_W-1:0] rem_q;
	logic [wsp_pkg::DVD_W-1:0]  quo_q;

	logic [wsp_pkg::TIME_W:0]   shifted;
	logic [wsp_pkg::TIME_W:0]   diff;
	logic                       ge;
	logic [wsp_pkg::TIME_W-1:0] rem_nx;

	always_comb begin
		shifted = {rem_q, quo_q[wsp_pkg::DVD_W-1]};
		diff    = shifted - {1'b0, divisor};
		ge      = shifted >= {1'b0, divisor};
		rem_nx  = ge ? diff[wsp_pkg::TIME_W-1:0] : shifted[wsp_pkg::TIME_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= wsp_pkg::CNT_W'(wsp_pkg::DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == wsp_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Dividend bits shift out of the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[wsp_pkg::DVD_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/wsp_mac.sv
// Shared signed multiply-accumulate unit: registered product, then accumulator.
// Depends on wsp_pkg for widths and the control struct.
module wsp_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wsp_pkg::mac_ctl_t                  ctl,
	input  logic signed [wsp_pkg::MUL_A_W-1:0] a,
	input  logic signed [wsp_pkg::MUL_B_W-1:0] b,
	output logic signed [wsp_pkg::PROD_W-1:0]  prod,
	output logic signed [wsp_pkg::PROD_W-1:0]  acc
);

	logic signed [wsp_pkg::PROD_W-1:0] prod_q;
	logic signed [wsp_pkg::PROD_W-1:0] acc_q;
	logic signed [wsp_pkg::PROD_W-1:0] prod_d;

	assign prod_d = a * b;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= prod_d;
		end
	end

	// The accumulator adds the product registered in the previous step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.acc_add) begin
			acc_q <= acc_q + prod_q;
		end
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule

FILE: rtl/wheel_speed_pid_pwm_core.sv
// Wheel speed PID controller with H-bridge duty output, top level.
// Depends on wsp_pkg, wsp_divider and wsp_mac.
//
//  Channel  Signals                    Content (lowest bit first)
//  s        s_tvalid/s_tready/s_tdata  pulses, elapsed_us, target_speed, stop
//           s_tuser                    wheel
//  m        m_tvalid/m_tready/m_tdata  duty_a, duty_b, measured_speed, speed_change,
//           m_tuser                    speed_valid; tuser: wheel_out
//  cfg      cfg_we/cfg_index/cfg_data  register write, no read-back
//
// A tick with nonzero elapsed time spends most of its way from input transfer to result
// in the 47 single-bit steps of the speed divider; a tick with zero elapsed time skips
// the scale multiply and the divider. The PID products share one multiplier, one per cycle.
// Reset clears the configuration to its defaults and all wheel state to zero.
// The input is accepted again as soon as the result is in the output register;
// a stalled output holds the sequencer in its last step until the transfer.
module wheel_speed_pid_pwm_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [wsp_pkg::IN_TDATA_W-1:0]      s_tdata,  // pulses, elapsed_us, target_speed, stop
	input  logic                                s_tuser,  // wheel
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [wsp_pkg::OUT_TDATA_W-1:0]     m_tdata,  // duty_a, duty_b, measured_speed,
	                                                      // speed_change, speed_valid
	output logic                                m_tuser,  // wheel_out
	input  logic                                cfg_we,
	input  logic [wsp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wsp_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam logic signed [wsp_pkg::PROD_W-1:0] ACC_FULL = wsp_pkg::PROD_W'(wsp_pkg::FULL_SCALE);
	localparam logic signed [wsp_pkg::DRV_W-1:0]  DRV_FULL = wsp_pkg::DRV_W'(wsp_pkg::FULL_SCALE);
	localparam logic [wsp_pkg::DUTY_W-1:0]        DUTY_FULL = wsp_pkg::DUTY_W'(wsp_pkg::FULL_SCALE);
	localparam logic [wsp_pkg::DVD_W-1:0]         Q_POS_MAX =
		wsp_pkg::DVD_W'(2 ** (wsp_pkg::SPEED_W - 1) - 1);
	localparam logic [wsp_pkg::DVD_W-1:0]         Q_NEG_MAX =
		wsp_pkg::DVD_W'(2 ** (wsp_pkg::SPEED_W - 1));

	// Input field views
	logic signed [wsp_pkg::SPEED_W-1:0] in_pulses;
	logic        [wsp_pkg::TIME_W-1:0]  in_elapsed;
	logic signed [wsp_pkg::SPEED_W-1:0] in_target;
	logic                               in_stop;
	logic        [wsp_pkg::WIDX_W-1:0]  in_widx;

	assign in_pulses  = s_tdata[15:0];
	assign in_elapsed = s_tdata[31:16];
	assign in_target  = s_tdata[47:32];
	assign in_stop    = s_tdata[48];
	assign in_widx    = (wsp_pkg::NUM_WHEELS > 1) ? wsp_pkg::WIDX_W'(s_tuser) : '0;

	// Configuration
	logic [wsp_pkg::GAIN_W-1:0]  kp_q;
	logic [wsp_pkg::GAIN_W-1:0]  ki_q;
	logic [wsp_pkg::GAIN_W-1:0]  kd_q;
	logic [wsp_pkg::SCALE_W-1:0] vscale_q;
	logic [wsp_pkg::DB_W-1:0]    db_q;
	logic                        gain_wr;

	// Per-wheel state
	logic signed [wsp_pkg::SPEED_W-1:0] wspeed_q [wsp_pkg::NUM_WHEELS];
	logic signed [wsp_pkg::SUM_W-1:0]   esum_q   [wsp_pkg::NUM_WHEELS];
	logic signed [wsp_pkg::ERR_W-1:0]   perr_q   [wsp_pkg::NUM_WHEELS];

	// Sequencer and working registers
	wsp_pkg::state_t                    state_q;
	logic                               wheel_q;
	logic        [wsp_pkg::WIDX_W-1:0]  widx_q;
	logic signed [wsp_pkg::SPEED_W-1:0] pulses_q;
	logic        [wsp_pkg::TIME_W-1:0]  elapsed_q;
	logic signed [wsp_pkg::SPEED_W-1:0] target_q;
	logic                               stop_q;
	logic signed [wsp_pkg::SPEED_W-1:0] speed_q;
	logic signed [wsp_pkg::SPEED_W-1:0] old_speed_q;
	logic                               valid_q;
	logic signed [wsp_pkg::ERR_W-1:0]   err_q;
	logic signed [wsp_pkg::DERIV_W-1:0] deriv_q;
	logic signed [wsp_pkg::SUM_W-1:0]   sum_q;
	logic signed [wsp_pkg::CHG_W-1:0]   change_q;
	logic signed [wsp_pkg::DRV_W-1:0]   drive_q;

	// Output register
	logic                               m_tvalid_q;
	logic [wsp_pkg::OUT_TDATA_W-1:0]    m_tdata_q;
	logic                               m_tuser_q;

	logic in_fire;
	logic out_load;

	assign s_tready = (state_q == wsp_pkg::ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_load = (state_q == wsp_pkg::ST_OUT) && (!m_tvalid_q || m_tready);
	assign gain_wr  = cfg_we && ((cfg_index == wsp_pkg::CFG_PROP_GAIN) ||
		(cfg_index == wsp_pkg::CFG_INTEGRAL_GAIN) || (cfg_index == wsp_pkg::CFG_DERIV_GAIN));

	// Shared arithmetic units
	wsp_pkg::mac_ctl_t                  mac_ctl;
	logic signed [wsp_pkg::MUL_A_W-1:0] mac_a;
	logic signed [wsp_pkg::MUL_B_W-1:0] mac_b;
	logic signed [wsp_pkg::PROD_W-1:0]  mac_prod;
	logic signed [wsp_pkg::PROD_W-1:0]  mac_acc;
	logic                               div_start;
	logic                               div_done;
	logic [wsp_pkg::DVD_W-1:0]          div_quo;
	logic [wsp_pkg::SPEED_W-1:0]        pulses_mag;

	assign pulses_mag = pulses_q[wsp_pkg::SPEED_W-1] ? wsp_pkg::SPEED_W'(-pulses_q)
	                                                 : wsp_pkg::SPEED_W'(pulses_q);
	assign div_start  = (state_q == wsp_pkg::ST_DSTART);

	always_comb begin
		mac_ctl = '0;
		mac_a   = '0;
		mac_b   = '0;
		case (state_q)
			wsp_pkg::ST_MULV: begin
				mac_ctl.mul_en = 1'b1;
				mac_a = {1'b0, vscale_q};
				mac_b = wsp_pkg::MUL_B_W'({1'b0, pulses_mag});
			end
			wsp_pkg::ST_MP: begin
				mac_ctl.mul_en  = 1'b1;
				mac_ctl.acc_clr = 1'b1;
				mac_a = wsp_pkg::MUL_A_W'(err_q);
				mac_b = {1'b0, kp_q};
			end
			wsp_pkg::ST_MI: begin
				mac_ctl.mul_en  = 1'b1;
				mac_ctl.acc_add = 1'b1;
				mac_a = wsp_pkg::MUL_A_W'(sum_q);
				mac_b = {1'b0, ki_q};
			end
			wsp_pkg::ST_MD: begin
				mac_ctl.mul_en  = 1'b1;
				mac_ctl.acc_add = 1'b1;
				mac_a = wsp_pkg::MUL_A_W'(deriv_q);
				mac_b = {1'b0, kd_q};
			end
			wsp_pkg::ST_MACC: begin
				mac_ctl.acc_add = 1'b1;
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	wsp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.prod   (mac_prod),
		.acc    (mac_acc)
	);

	wsp_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mac_prod[wsp_pkg::DVD_W-1:0]),
		.divisor  (elapsed_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Datapath steps
	logic signed [wsp_pkg::SPEED_W-1:0] speed_sat;
	logic signed [wsp_pkg::ERR_W-1:0]   err_d;
	logic signed [wsp_pkg::SUM_W:0]     sum_wide;
	logic signed [wsp_pkg::SUM_W-1:0]   sum_d;
	logic signed [wsp_pkg::PROD_W-1:0]  acc_sh;
	logic signed [wsp_pkg::DRV_W-1:0]   drive_d;
	logic        [wsp_pkg::DRV_W-1:0]   drive_mag;
	logic signed [wsp_pkg::DRV_W-1:0]   drive_fin;
	logic signed [wsp_pkg::DRV_W-1:0]   duty_a_w;
	logic signed [wsp_pkg::DRV_W-1:0]   duty_b_w;

	always_comb begin
		if (pulses_q[wsp_pkg::SPEED_W-1]) begin
			speed_sat = (div_quo > Q_NEG_MAX) ? wsp_pkg::SPEED_W'(Q_NEG_MAX)
			                                  : -div_quo[wsp_pkg::SPEED_W-1:0];
		end else begin
			speed_sat = (div_quo > Q_POS_MAX) ? wsp_pkg::SPEED_W'(Q_POS_MAX)
			                                  : div_quo[wsp_pkg::SPEED_W-1:0];
		end

		err_d    = wsp_pkg::ERR_W'(target_q) - wsp_pkg::ERR_W'(speed_q);
		sum_wide = (wsp_pkg::SUM_W + 1)'(esum_q[widx_q]) + (wsp_pkg::SUM_W + 1)'(err_d);
		if (sum_wide[wsp_pkg::SUM_W] != sum_wide[wsp_pkg::SUM_W-1]) begin
			// Saturate toward the sign of the true sum.
			sum_d = sum_wide[wsp_pkg::SUM_W] ? {1'b1, {(wsp_pkg::SUM_W - 1){1'b0}}}
			                                 : {1'b0, {(wsp_pkg::SUM_W - 1){1'b1}}};
		end else begin
			sum_d = sum_wide[wsp_pkg::SUM_W-1:0];
		end

		// Arithmetic shift gives the floor of the division by the gain scale.
		acc_sh = mac_acc >>> wsp_pkg::GAIN_FRAC;
		if (acc_sh > ACC_FULL) begin
			drive_d = DRV_FULL;
		end else if (acc_sh < -ACC_FULL) begin
			drive_d = -DRV_FULL;
		end else begin
			drive_d = acc_sh[wsp_pkg::DRV_W-1:0];
		end

		drive_mag = drive_q[wsp_pkg::DRV_W-1] ? wsp_pkg::DRV_W'(-drive_q)
		                                      : wsp_pkg::DRV_W'(drive_q);
		if (stop_q || (32'(drive_mag) < 32'(db_q))) begin
			drive_fin = '0;
		end else begin
			drive_fin = drive_q;
		end

		duty_a_w = DRV_FULL;
		duty_b_w = DRV_FULL;
		if (drive_fin < 0) begin
			duty_b_w = DRV_FULL + drive_fin;
		end else if (drive_fin > 0) begin
			duty_a_w = DRV_FULL - drive_fin;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsp_pkg::ST_IDLE;
		end else begin
			case (state_q)
				wsp_pkg::ST_IDLE: begin
					if (in_fire) begin
						state_q <= (in_elapsed != '0) ? wsp_pkg::ST_MULV : wsp_pkg::ST_PREP;
					end
				end
				wsp_pkg::ST_MULV:   state_q <= wsp_pkg::ST_DSTART;
				wsp_pkg::ST_DSTART: state_q <= wsp_pkg::ST_DIV;
				wsp_pkg::ST_DIV: begin
					if (div_done) begin
						state_q <= wsp_pkg::ST_PREP;
					end
				end
				wsp_pkg::ST_PREP:   state_q <= wsp_pkg::ST_MP;
				wsp_pkg::ST_MP:     state_q <= wsp_pkg::ST_MI;
				wsp_pkg::ST_MI:     state_q <= wsp_pkg::ST_MD;
				wsp_pkg::ST_MD:     state_q <= wsp_pkg::ST_MACC;
				wsp_pkg::ST_MACC:   state_q <= wsp_pkg::ST_CLAMP;
				wsp_pkg::ST_CLAMP:  state_q <= wsp_pkg::ST_OUT;
				wsp_pkg::ST_OUT: begin
					if (out_load) begin
						state_q <= wsp_pkg::ST_IDLE;
					end
				end
				default: state_q <= wsp_pkg::ST_IDLE;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			wheel_q     <= s_tuser;
			widx_q      <= in_widx;
			pulses_q    <= in_pulses;
			elapsed_q   <= in_elapsed;
			target_q    <= in_target;
			stop_q      <= in_stop;
			old_speed_q <= wspeed_q[in_widx];
			speed_q     <= wspeed_q[in_widx];
			valid_q     <= 1'b0;
		end
		if ((state_q == wsp_pkg::ST_DIV) && div_done) begin
			speed_q <= speed_sat;
			valid_q <= 1'b1;
		end
		if (state_q == wsp_pkg::ST_PREP) begin
			err_q    <= err_d;
			deriv_q  <= wsp_pkg::DERIV_W'(err_d) - wsp_pkg::DERIV_W'(perr_q[widx_q]);
			sum_q    <= sum_d;
			change_q <= valid_q ? wsp_pkg::CHG_W'(speed_q) - wsp_pkg::CHG_W'(old_speed_q) : '0;
		end
		if (state_q == wsp_pkg::ST_CLAMP) begin
			drive_q <= drive_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= '0;
			ki_q     <= '0;
			kd_q     <= '0;
			vscale_q <= '0;
			db_q     <= wsp_pkg::DEADBAND_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wsp_pkg::CFG_PROP_GAIN:      kp_q     <= cfg_data[wsp_pkg::GAIN_W-1:0];
				wsp_pkg::CFG_INTEGRAL_GAIN:  ki_q     <= cfg_data[wsp_pkg::GAIN_W-1:0];
				wsp_pkg::CFG_DERIV_GAIN:     kd_q     <= cfg_data[wsp_pkg::GAIN_W-1:0];
				wsp_pkg::CFG_VELOCITY_SCALE: vscale_q <= cfg_data[wsp_pkg::SCALE_W-1:0];
				wsp_pkg::CFG_DEADBAND:       db_q     <= cfg_data[wsp_pkg::DB_W-1:0];
				default: ;
			endcase
		end
	end

	// Wheel state: a gain write clears every wheel; a result commits one wheel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wsp_pkg::NUM_WHEELS; i++) begin
				wspeed_q[i] <= '0;
				esum_q[i]   <= '0;
				perr_q[i]   <= '0;
			end
		end else if (gain_wr) begin
			for (int i = 0; i < wsp_pkg::NUM_WHEELS; i++) begin
				wspeed_q[i] <= '0;
				esum_q[i]   <= '0;
				perr_q[i]   <= '0;
			end
		end else if (out_load) begin
			if (stop_q) begin
				wspeed_q[widx_q] <= '0;
				esum_q[widx_q]   <= '0;
				perr_q[widx_q]   <= '0;
			end else begin
				wspeed_q[widx_q] <= speed_q;
				esum_q[widx_q]   <= sum_q;
				perr_q[widx_q]   <= err_q;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser_q <= wheel_q;
			m_tdata_q <= {4'b0000, valid_q, change_q, speed_q,
			              wsp_pkg::DUTY_W'(duty_b_w), wsp_pkg::DUTY_W'(duty_a_w)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("input accepted while a tick is in progress");

	a_one_duty_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (m_tdata_q[12:0] == DUTY_FULL) || (m_tdata_q[25:13] == DUTY_FULL))
		else $error("neither bridge duty is at full scale");

	a_no_change_without_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tdata_q[59]) |-> (m_tdata_q[58:42] == '0))
		else $error("speed change reported without a speed update");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == wsp_pkg::ST_DIV))
		else $error("divider finished outside the divide step");

endmodule
